// File: rtl/hcbp_pkg.sv
package hcbp_pkg;

  // field widths
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int CNT_W   = 3;
  localparam int ROOM_W  = 4;

  // code table limits
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int TABLE_DEPTH  = 2 ** SYM_W;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // stream packing
  localparam int IN_DATA_W = 48;

  // command codes
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_ENCODE = 2'd1;
  localparam cmd_t CMD_FLUSH  = 2'd2;

  // one table entry
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // request to the code table
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SYM_W-1:0] addr;
    entry_t           wdata;
  } mem_req_t;

  // clamp a length to the supported maximum
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(LEN_LIMIT);
    return (len > lim) ? lim : len;
  endfunction

endpackage

// File: rtl/hcbp_code_mem.sv
module hcbp_code_mem import hcbp_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];

  // single port table, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// File: rtl/hcbp_shift_unit.sv
module hcbp_shift_unit import hcbp_pkg::*; (
  input  logic [CODE_W-1:0] operand,
  input  logic [LEN_W-1:0]  amount,
  output logic [CODE_W-1:0] result
);

  // left shift, zero fill, full width shift clears the word
  always_comb begin
    if (amount >= LEN_W'(CODE_W)) begin
      result = '0;
    end else begin
      result = operand << amount;
    end
  end

endmodule

// File: rtl/huffman_code_bit_packer.sv
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser: cmd; s_tdata: symbol, code_word, code_length
// m_*      out  m_tvalid/m_tready  m_tdata: out_byte; m_tlast: last
//
// load writes a table entry; flush passes through the flush state if bits are buffered;
// encode reads the table, aligns the code, then takes steps of the shared shifter, which
// moves up to 8 code bits into the byte register per step, for a code of 1 to 32 bits.
// one output register; a byte-ending step or a flush waits while it is full and not read.
// rst clears the sequencer, the bit buffer and the output valid; the code
// table holds no reset value.
module huffman_code_bit_packer import hcbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,  // symbol[7:0], code_word[39:8], code_length[45:40]
  input  logic [CMD_W-1:0]     s_tuser,  // cmd[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,  // out_byte[7:0]
  output logic                 m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_STEP,
    ST_FLUSH
  } state_t;

  state_t              state;
  logic [BYTE_W-1:0]   acc;
  logic [CNT_W-1:0]    cnt;
  logic [CODE_W-1:0]   pend;
  logic [LEN_W-1:0]    pend_len;
  logic [BYTE_W-1:0]   out_data;
  logic                out_last;
  logic                out_valid;

  logic                accept;
  cmd_t                cmd;
  logic [SYM_W-1:0]    sym;
  logic                sym_ok;
  mem_req_t            mem_req;
  entry_t              rd_data;
  logic [LEN_W-1:0]    rd_len;
  logic [CODE_W-1:0]   sh_operand;
  logic [LEN_W-1:0]    sh_amount;
  logic [CODE_W-1:0]   sh_result;
  logic [ROOM_W-1:0]   room;
  logic [LEN_W-1:0]    take;
  logic [ROOM_W-1:0]   fill;
  logic                full;
  logic [BYTE_W-1:0]   merged;
  logic                out_free;
  logic                load_out;

  // request decode
  assign accept   = s_tvalid && s_tready;
  assign cmd      = s_tuser;
  assign sym      = s_tdata[SYM_W-1:0];
  assign sym_ok   = {1'b0, sym} < (SYM_W+1)'(SYMBOL_COUNT);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;

  // code table access
  always_comb begin
    mem_req.wr_en      = accept && (cmd == CMD_LOAD) && sym_ok;
    mem_req.rd_en      = accept && (cmd == CMD_ENCODE) && sym_ok;
    mem_req.addr       = sym;
    mem_req.wdata.code = s_tdata[SYM_W +: CODE_W];
    mem_req.wdata.len  = sat_len(s_tdata[SYM_W+CODE_W +: LEN_W]);
  end

  hcbp_code_mem u_code_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign rd_len = sat_len(rd_data.len);

  // shared shifter: left-align the code, then drop the bits already packed
  always_comb begin
    if (state == ST_ALIGN) begin
      sh_operand = rd_data.code;
      sh_amount  = LEN_W'(CODE_W) - rd_len;
    end else begin
      sh_operand = pend;
      sh_amount  = take;
    end
  end

  hcbp_shift_unit u_shift (
    .operand (sh_operand),
    .amount  (sh_amount),
    .result  (sh_result)
  );

  // bits moved into the byte register this step
  always_comb begin
    room   = ROOM_W'(BYTE_W) - {1'b0, cnt};
    take   = (pend_len < LEN_W'(room)) ? pend_len : LEN_W'(room);
    fill   = {1'b0, cnt} + take[ROOM_W-1:0];
    full   = (fill == ROOM_W'(BYTE_W));
    merged = acc | (pend[CODE_W-1 -: BYTE_W] >> cnt);
  end

  // a byte enters the output register
  assign load_out = out_free && ((state == ST_STEP && full) || state == ST_FLUSH);

  // sequencer, bit buffer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      cnt       <= '0;
      pend_len  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_ENCODE: begin
                if (sym_ok) begin
                  state <= ST_ALIGN;
                end
              end
              CMD_FLUSH: begin
                if (cnt != '0) begin
                  state <= ST_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ALIGN: begin
          pend     <= sh_result;
          pend_len <= rd_len;
          state    <= (rd_len == '0) ? ST_IDLE : ST_STEP;
        end
        ST_STEP: begin
          if (!full || out_free) begin
            pend     <= sh_result;
            pend_len <= pend_len - take;
            if (full) begin
              // last unless the remaining bits fill another byte
              out_data <= merged;
              out_last <= ((pend_len - take) < LEN_W'(BYTE_W));
              acc      <= '0;
              cnt      <= '0;
            end else begin
              acc <= merged;
              cnt <= fill[CNT_W-1:0];
            end
            if (pend_len == take) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_data <= acc;
            out_last <= 1'b1;
            acc      <= '0;
            cnt      <= '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  // pending code never exceeds the longest code
  a_pend_len: assert property (@(posedge clk) disable iff (rst)
    pend_len <= LEN_W'(LEN_LIMIT))
    else $error("pending length out of range");

  // an encode request blocks the input for the table read
  a_encode_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_ENCODE) && sym_ok) |=> !s_tready)
    else $error("input ready right after encode request");

  // a new byte comes only from a packing step or a flush
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_STEP || $past(state) == ST_FLUSH))
    else $error("output byte from unexpected state");

  // a flush empties the bit buffer
  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (cnt == '0 && acc == '0))
    else $error("bit buffer not empty after flush");
`endif

endmodule
